FILE: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types for the deque with cursor
// Operation codes and the per-result status flags.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CUR_FRONT  = 3'd4,
    OP_CUR_BACK   = 3'd5,
    OP_STEP_NEXT  = 3'd6,
    OP_STEP_PREV  = 3'd7
  } op_e;

  // Status that travels with each result
  typedef struct packed {
    logic data_valid;
    logic rejected;
    logic is_empty;
  } res_flags_t;

endpackage

`default_nettype wire

FILE: design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: generic single-port RAM
// One write or one read per cycle, read data registered and held.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: pointer state and operation decode
// Holds front, occupancy and cursor; turns one operation into at most one RAM access.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         fire_i,
  input  wire logic [2:0]                   op_i,
  input  wire logic [WORD_WIDTH-1:0]        data_i,
  output logic                              ram_we_o,
  output logic                              ram_re_o,
  output logic      [$clog2(DEPTH)-1:0]     ram_addr_o,
  output logic      [WORD_WIDTH-1:0]        ram_wdata_o,
  output deq_pkg::res_flags_t               flags_o,
  output logic      [$clog2(DEPTH+1)-1:0]   count_o
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);
  localparam logic [SW-1:0] DepthS  = SW'(DEPTH);

  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [AW-1:0] cur_q, cur_d;
  logic          cur_vld_q, cur_vld_d;

  logic [AW-1:0] front_inc, front_dec, cur_inc, cur_dec;
  logic [SW-1:0] sum_tail, sum_back;
  logic [AW-1:0] tail_idx, back_idx;
  logic          full, empty;
  op_e           op;

  assign op    = op_e'(op_i);
  assign full  = (occ_q == FullCnt);
  assign empty = (occ_q == '0);

  assign front_inc = (front_q == LastIdx) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign cur_inc   = (cur_q == LastIdx) ? '0 : cur_q + AW'(1);
  assign cur_dec   = (cur_q == '0) ? LastIdx : cur_q - AW'(1);

  // Slot after the back and the back slot itself, wrapped once
  assign sum_tail = SW'(front_q) + SW'(occ_q);
  assign sum_back = sum_tail - SW'(1);
  assign tail_idx = (sum_tail >= DepthS) ? AW'(sum_tail - DepthS) : AW'(sum_tail);
  assign back_idx = (sum_back >= DepthS) ? AW'(sum_back - DepthS) : AW'(sum_back);

  always_comb begin
    front_d     = front_q;
    occ_d       = occ_q;
    cur_d       = cur_q;
    cur_vld_d   = cur_vld_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = front_q;
    ram_wdata_o = data_i;
    flags_o     = '0;

    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          flags_o.rejected = 1'b1;
        end else begin
          front_d    = front_dec;
          ram_we_o   = fire_i;
          ram_addr_o = front_dec;
          occ_d      = occ_q + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          flags_o.rejected = 1'b1;
        end else begin
          ram_we_o   = fire_i;
          ram_addr_o = tail_idx;
          occ_d      = occ_q + CW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (!empty) begin
          ram_addr_o         = (op == OP_POP_FRONT) ? front_q : back_idx;
          ram_re_o           = fire_i;
          flags_o.data_valid = 1'b1;
          if (cur_vld_q && (cur_q == ram_addr_o)) begin
            cur_vld_d = 1'b0;
          end
          if (op == OP_POP_FRONT) begin
            front_d = front_inc;
          end
          occ_d = occ_q - CW'(1);
        end
      end
      OP_CUR_FRONT, OP_CUR_BACK: begin
        if (empty) begin
          cur_vld_d = 1'b0;
        end else begin
          cur_d     = (op == OP_CUR_FRONT) ? front_q : back_idx;
          cur_vld_d = 1'b1;
        end
      end
      OP_STEP_NEXT, OP_STEP_PREV: begin
        if (cur_vld_q) begin
          ram_addr_o         = cur_q;
          ram_re_o           = fire_i;
          flags_o.data_valid = 1'b1;
          if (op == OP_STEP_NEXT) begin
            if (cur_q == back_idx) cur_vld_d = 1'b0;
            else                   cur_d     = cur_inc;
          end else begin
            if (cur_q == front_q)  cur_vld_d = 1'b0;
            else                   cur_d     = cur_dec;
          end
        end
      end
      default: ;
    endcase

    flags_o.is_empty = (occ_d == '0);
  end

  assign count_o = occ_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      occ_q     <= '0;
      cur_q     <= '0;
      cur_vld_q <= 1'b0;
    end else if (fire_i) begin
      front_q   <= front_d;
      occ_q     <= occ_d;
      cur_q     <= cur_d;
      cur_vld_q <= cur_vld_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/deque_with_cursor_top.sv
// Throughput: one operation per cycle while no result stalls; an accepted
//   operation passes the input register, then the result register with the
//   RAM read port, which together form a two-stage pipeline.
// Reset: rst_ni (async, active low) empties the queue and drops the cursor;
//   the ring RAM is not cleared, and only occupied slots are ever read.
// ----------------------------------------------------------------------------
// deque_with_cursor_top: bounded double-ended queue with a cursor
// Ring store in a single-port RAM, pointer logic in deq_ctrl, one result
// per operation carrying the count and an empty flag.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_cursor_top #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // operation channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [2:0]                 operation_i,
  input  wire logic [WORD_WIDTH-1:0]      data_in_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [WORD_WIDTH-1:0]      data_out_o,
  output logic                            data_valid_o,
  output logic                            rejected_o,
  output logic      [$clog2(DEPTH+1)-1:0] element_count_o,
  output logic                            is_empty_o
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Stage 0: input register
  logic                  s0_valid_q;
  logic [2:0]            s0_op_q;
  logic [WORD_WIDTH-1:0] s0_data_q;

  // Stage 1: result register (data word lives in the RAM read register)
  logic                  s1_valid_q;
  res_flags_t            s1_flags_q;
  logic [CW-1:0]         s1_count_q;

  logic                  advance;
  logic                  fire;
  logic                  in_xact;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_addr;
  logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
  res_flags_t            flags;
  logic [CW-1:0]         count;

  // The pipeline moves whenever the result slot is free or being drained.
  // The RAM read register only loads on fire, so a stalled result holds.
  assign advance    = !s1_valid_q || out_ready_i;
  assign fire       = s0_valid_q && advance;
  assign in_ready_o = !s0_valid_q || advance;
  assign in_xact    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xact)      s0_valid_q <= 1'b1;
      else if (advance) s0_valid_q <= 1'b0;
      if (advance)      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      s0_op_q   <= operation_i;
      s0_data_q <= data_in_i;
    end
    if (fire) begin
      s1_flags_q <= flags;
      s1_count_q <= count;
    end
  end

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (s0_op_q),
    .data_i      (s0_data_q),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .flags_o     (flags),
    .count_o     (count)
  );

  // Each operation writes or reads at most one slot, never both, so a read
  // right after a write to the same slot sees the new word.
  deq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = s1_valid_q;
  assign data_out_o      = s1_flags_q.data_valid ? ram_rdata : '0;
  assign data_valid_o    = s1_flags_q.data_valid;
  assign rejected_o      = s1_flags_q.rejected;
  assign element_count_o = s1_count_q;
  assign is_empty_o      = s1_flags_q.is_empty;

endmodule

`default_nettype wire

FILE: design/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker: port-level checks for the deque with cursor
// Bound to the top level; watches only its ports.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [WORD_WIDTH-1:0]      data_out_o,
  input wire logic                       data_valid_o,
  input wire logic                       rejected_o,
  input wire logic [$clog2(DEPTH+1)-1:0] element_count_o,
  input wire logic                       is_empty_o
);

  localparam int CW = $clog2(DEPTH + 1);

  a_reject_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> !data_valid_o)
    else $error("rejected push carries data");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (element_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (element_count_o <= CW'(DEPTH)))
    else $error("count above depth");

  a_no_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> (data_out_o == '0))
    else $error("data word not zero without data");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o)
      && $stable(element_count_o))
    else $error("stalled result changed");

endmodule

bind deque_with_cursor_top deq_checker #(
  .DEPTH      (DEPTH),
  .WORD_WIDTH (WORD_WIDTH)
) u_deq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .data_out_o      (data_out_o),
  .data_valid_o    (data_valid_o),
  .rejected_o      (rejected_o),
  .element_count_o (element_count_o),
  .is_empty_o      (is_empty_o)
);

`default_nettype wire
